// ----- rtl/rrt_pkg.sv -----
`default_nettype none
package rrt_pkg;
  localparam int TreeDepth    = 4096;
  localparam int CoordBits    = 10;
  localparam int UnitFracBits = 16;
  localparam int CfgBits      = 12;
  localparam int IdxBits      = 12;
  localparam logic [7:0]  DefStepLen  = 8'd4;
  localparam logic [11:0] DefMaxSteps = 12'd3000;

  typedef enum logic [2:0] {
    CfgGoalX  = 3'd0,
    CfgGoalY  = 3'd1,
    CfgStartX = 3'd2,
    CfgStartY = 3'd3,
    CfgStep   = 3'd4,
    CfgMax    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } unit_ctl_t;
endpackage
`default_nettype wire

// ----- rtl/rrt_tree_extend_core.sv -----
`default_nettype none
// Restart writes the goal as vertex 0 and answers straight from idle; extend
// scans the vertex memory (one read per cycle), then runs the two unit-vector
// searches when the nearest vertex is beyond step_len.
// One beat at a time: the input stalls while a beat is in work or its result
// is still held. Result waits in an output register. Reset clears control and
// config registers; vertex memory is not cleared, only slots below the count
// are ever read.
module rrt_tree_extend_core #(
  parameter int TREE_DEPTH     = rrt_pkg::TreeDepth,
  parameter int COORD_BITS     = rrt_pkg::CoordBits,
  parameter int UNIT_FRAC_BITS = rrt_pkg::UnitFracBits
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [2:0]             cfg_idx_i,
  input  wire logic [rrt_pkg::CfgBits-1:0] cfg_data_i,
  input  wire logic                   in_valid_i,
  output      logic                   in_stall_o,
  input  wire logic                   req_type_i,
  input  wire logic [COORD_BITS-1:0]  sample_x_i,
  input  wire logic [COORD_BITS-1:0]  sample_y_i,
  output      logic                   out_valid_o,
  input  wire logic                   out_stall_i,
  output      logic                   accepted_o,
  output      logic [COORD_BITS-1:0]  near_x_o,
  output      logic [COORD_BITS-1:0]  near_y_o,
  output      logic [COORD_BITS-1:0]  new_x_o,
  output      logic [COORD_BITS-1:0]  new_y_o,
  output      logic [rrt_pkg::IdxBits-1:0] new_index_o,
  output      logic                   reached_start_o,
  output      logic                   tree_done_o
);
  import rrt_pkg::*;
  localparam int AB = $clog2(TREE_DEPTH);
  localparam int CB = AB + 1;
  localparam int DB = 2 * COORD_BITS + 1;
  localparam int UB = UNIT_FRAC_BITS + 1;
  localparam int MB = UB + 8;

  typedef enum logic [7:0] {
    StIdle  = 8'b00000001,
    StScan  = 8'b00000010,
    StDecid = 8'b00000100,
    StUx    = 8'b00001000,
    StUy    = 8'b00010000,
    StWrite = 8'b00100000,
    StOut   = 8'b01000000,
    StFin   = 8'b10000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [COORD_BITS-1:0] goal_x_q, goal_y_q, start_x_q, start_y_q;
  logic [7:0]  step_q;
  logic [11:0] max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q <= '0; goal_y_q <= '0; start_x_q <= '0; start_y_q <= '0;
      step_q <= DefStepLen;
      max_q  <= DefMaxSteps;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgGoalX:  goal_x_q  <= COORD_BITS'(cfg_data_i[9:0]);
        CfgGoalY:  goal_y_q  <= COORD_BITS'(cfg_data_i[9:0]);
        CfgStartX: start_x_q <= COORD_BITS'(cfg_data_i[9:0]);
        CfgStartY: start_y_q <= COORD_BITS'(cfg_data_i[9:0]);
        CfgStep:   step_q    <= cfg_data_i[7:0];
        CfgMax:    max_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // vertex memory: x and y packed into one word
  logic [2*COORD_BITS-1:0] mem_q [TREE_DEPTH];
  logic [2*COORD_BITS-1:0] rd_q;
  logic            mem_we;
  logic [AB-1:0]   mem_wa, mem_ra;
  logic [2*COORD_BITS-1:0] mem_wd;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rd_q <= mem_q[mem_ra];
  end

  logic [CB-1:0] count_q;
  logic [11:0]   steps_q;
  logic          fin_q;
  logic [COORD_BITS-1:0] sx_q, sy_q;
  logic [CB-1:0] ra_q;       // next address to issue
  logic          rv_q;       // rd_q holds a valid vertex this cycle
  logic [DB-1:0] best_d2_q;
  logic [COORD_BITS-1:0] nx_q, ny_q, wx_q, wy_q;
  logic          first_q;

  // output register
  logic ov_q, oacc_q, ohit_q, odone_q;
  logic [COORD_BITS-1:0] onx_q, ony_q, owx_q, owy_q;
  logic [IdxBits-1:0] oidx_q;

  logic in_acc;
  assign in_stall_o = (state_q != StIdle) || ov_q;
  assign in_acc     = in_valid_i && !in_stall_o;

  // squared distance of the word just read
  logic [COORD_BITS-1:0] vx, vy, adx, ady;
  logic [DB-1:0] d2;
  assign vx  = rd_q[2*COORD_BITS-1:COORD_BITS];
  assign vy  = rd_q[COORD_BITS-1:0];
  assign adx = (vx >= sx_q) ? vx - sx_q : sx_q - vx;
  assign ady = (vy >= sy_q) ? vy - sy_q : sy_q - vy;
  assign d2  = DB'(adx) * DB'(adx) + DB'(ady) * DB'(ady);

  // unit vector unit, shared by both axes
  unit_ctl_t ctl;
  logic [COORD_BITS-1:0] ddx, ddy, udin;
  logic [UB-1:0] u;
  assign ddx  = (sx_q >= nx_q) ? sx_q - nx_q : nx_q - sx_q;
  assign ddy  = (sy_q >= ny_q) ? sy_q - ny_q : ny_q - sy_q;
  assign udin = (state_q == StUy) ? ddy : ddx;

  logic ustarted_q;
  assign ctl.start = ((state_q == StUx) || (state_q == StUy)) && !ustarted_q;

  rrt_unit #(.COORD_BITS(COORD_BITS), .UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_unit (
    .clk_i, .rst_ni,
    .start_i(ctl.start), .dabs_i(udin), .d2_i(best_d2_q),
    .busy_o(ctl.busy), .done_o(ctl.done), .u_o(u)
  );

  // step along one axis, floor of the signed offset
  logic [MB-1:0] m;
  logic [MB-UNIT_FRAC_BITS-1:0] whole;
  logic [COORD_BITS-1:0] nc, sc, adv;
  assign m     = MB'(step_q) * MB'(u);
  assign nc    = (state_q == StUy) ? ny_q : nx_q;
  assign sc    = (state_q == StUy) ? sy_q : sx_q;
  assign whole = m[MB-1:UNIT_FRAC_BITS];
  always_comb begin
    if (sc >= nc) adv = nc + COORD_BITS'(whole);
    else adv = nc - COORD_BITS'(whole) - COORD_BITS'(m[UNIT_FRAC_BITS-1:0] != '0);
  end

  logic hit;
  logic [11:0] steps_nx;
  assign hit      = (wx_q == start_x_q) && (wy_q == start_y_q);
  assign steps_nx = steps_q + 12'd1;

  always_comb begin
    state_d = state_q;
    mem_we  = 1'b0;
    mem_wa  = count_q[AB-1:0];
    mem_wd  = {wx_q, wy_q};
    mem_ra  = ra_q[AB-1:0];
    case (state_q)
      StIdle:  if (in_acc) begin
        if (!req_type_i) state_d = StIdle;
        else if (count_q == '0 || fin_q || count_q >= CB'(TREE_DEPTH)) state_d = StIdle;
        else state_d = StScan;
      end
      StScan:  if (ra_q >= count_q && !rv_q) state_d = StDecid;
      StDecid: begin
        if (best_d2_q < DB'(step_q) * DB'(step_q) || best_d2_q == '0) state_d = StWrite;
        else state_d = StUx;
      end
      StUx:    if (ctl.done) state_d = StUy;
      StUy:    if (ctl.done) state_d = StWrite;
      StWrite: begin
        mem_we  = 1'b1;
        state_d = StOut;
      end
      StOut:   state_d = StIdle;
      StFin:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
    if (state_q == StIdle && in_acc && !req_type_i) begin
      mem_we = 1'b1;
      mem_wa = '0;
      mem_wd = {goal_x_q, goal_y_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      count_q    <= '0;
      steps_q    <= '0;
      fin_q      <= 1'b0;
      ov_q       <= 1'b0;
      rv_q       <= 1'b0;
      ra_q       <= '0;
      ustarted_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      case (state_q)
        StIdle: if (in_acc) begin
          ra_q <= '0;
          rv_q <= 1'b0;
          if (!req_type_i) begin
            count_q <= CB'(1);
            steps_q <= '0;
            fin_q   <= 1'b0;
            ov_q    <= 1'b1;
          end else if (count_q == '0 || fin_q || count_q >= CB'(TREE_DEPTH)) begin
            if (count_q >= CB'(TREE_DEPTH)) fin_q <= 1'b1;
            ov_q <= 1'b1;
          end
        end
        StScan: begin
          rv_q <= (ra_q < count_q);
          if (ra_q < count_q) ra_q <= ra_q + 1'b1;
        end
        StUx, StUy: begin
          if (ctl.start) ustarted_q <= 1'b1;
          if (ctl.done)  ustarted_q <= 1'b0;
        end
        StWrite: begin
          count_q <= count_q + 1'b1;
          steps_q <= steps_nx;
        end
        StOut: begin
          ov_q <= 1'b1;
          if (hit || steps_q >= max_q || count_q >= CB'(TREE_DEPTH)) fin_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: if (in_acc) begin
        sx_q    <= sample_x_i;
        sy_q    <= sample_y_i;
        first_q <= 1'b1;
        oacc_q  <= 1'b0;
        ohit_q  <= 1'b0;
        oidx_q  <= '0;
        if (!req_type_i) begin
          onx_q <= goal_x_q; ony_q <= goal_y_q;
          owx_q <= goal_x_q; owy_q <= goal_y_q;
          odone_q <= 1'b0;
        end else begin
          onx_q <= '0; ony_q <= '0; owx_q <= '0; owy_q <= '0;
          odone_q <= fin_q || count_q >= CB'(TREE_DEPTH);
        end
      end
      StScan: if (rv_q) begin
        first_q <= 1'b0;
        if (first_q || d2 <= best_d2_q) begin
          best_d2_q <= d2;
          nx_q <= vx;
          ny_q <= vy;
        end
      end
      StDecid: begin
        if (best_d2_q < DB'(step_q) * DB'(step_q)) begin
          wx_q <= sx_q; wy_q <= sy_q;
        end else begin
          wx_q <= nx_q; wy_q <= ny_q;
        end
      end
      StUx: if (ctl.done) wx_q <= adv;
      StUy: if (ctl.done) wy_q <= adv;
      StOut: begin
        oacc_q  <= 1'b1;
        onx_q   <= nx_q; ony_q <= ny_q;
        owx_q   <= wx_q; owy_q <= wy_q;
        oidx_q  <= IdxBits'(count_q - 1'b1);
        ohit_q  <= hit;
        odone_q <= fin_q || hit || steps_q >= max_q || count_q >= CB'(TREE_DEPTH);
      end
      default: ;
    endcase
  end

  assign out_valid_o     = ov_q;
  assign accepted_o      = oacc_q;
  assign near_x_o        = onx_q;
  assign near_y_o        = ony_q;
  assign new_x_o         = owx_q;
  assign new_y_o         = owy_q;
  assign new_index_o     = oidx_q;
  assign reached_start_o = ohit_q;
  assign tree_done_o     = odone_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_acc) else $error("beat taken while busy");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CB'(TREE_DEPTH)) else $error("vertex count overflow");
  a_write_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWrite) |=> (count_q == $past(count_q) + 1'b1))
    else $error("write did not advance count");
endmodule
`default_nettype wire

// ----- rtl/rrt_unit.sv -----
`default_nettype none
// Unit-vector component magnitude: bit-serial search for the largest u with
// u^2 * d2 <= d^2 * 2^(2F), one bit per trial, each trial in two phases
// (square, then compare), so each multiply has a register after it.
module rrt_unit #(
  parameter int COORD_BITS     = 10,
  parameter int UNIT_FRAC_BITS = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [COORD_BITS-1:0]     dabs_i,
  input  wire logic [2*COORD_BITS:0]     d2_i,
  output      logic                      busy_o,
  output      logic                      done_o,
  output      logic [UNIT_FRAC_BITS:0]   u_o
);
  import rrt_pkg::*;
  localparam int UB = UNIT_FRAC_BITS + 1;
  localparam int DB = 2 * COORD_BITS + 1;
  localparam int RB = 2 * COORD_BITS + 2 * UNIT_FRAC_BITS;
  localparam int PB = 2 * UB + DB;
  localparam int BB = $clog2(UB + 1);

  logic [UB-1:0] u_q, c_q;
  logic [2*UB-1:0] cc_q;
  logic [RB-1:0] rhs_q;
  logic [DB-1:0] d2_q;
  logic [BB-1:0] bit_q;
  logic phase_q, busy_q, done_q;
  logic [PB-1:0] prod;

  assign prod = PB'(cc_q) * PB'(d2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      bit_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
        bit_q   <= BB'(UNIT_FRAC_BITS);
      end else if (busy_q) begin
        phase_q <= !phase_q;
        if (phase_q) begin
          if (bit_q == '0) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            bit_q <= bit_q - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      u_q   <= '0;
      d2_q  <= d2_i;
      rhs_q <= RB'(dabs_i) * RB'(dabs_i) << (2 * UNIT_FRAC_BITS);
    end else if (busy_q) begin
      if (!phase_q) begin
        c_q  <= u_q | (UB'(1) << bit_q);
        cc_q <= (2*UB)'(u_q | (UB'(1) << bit_q)) * (2*UB)'(u_q | (UB'(1) << bit_q));
      end else if (prod <= PB'(rhs_q)) begin
        u_q <= c_q;
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign u_o    = u_q;
endmodule
`default_nettype wire

// ----- verif/rrt_tree_extend_core_tb.sv -----
`timescale 1ns / 1ps
module rrt_tree_extend_core_tb;
  import rrt_pkg::*;

  localparam int CoordMask = (1 << CoordBits) - 1;
  localparam int QuietLimit = 200000;

  typedef struct packed {
    logic        accepted;
    logic [9:0]  near_x;
    logic [9:0]  near_y;
    logic [9:0]  new_x;
    logic [9:0]  new_y;
    logic [11:0] new_index;
    logic        reached_start;
    logic        tree_done;
  } edge_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [CfgBits-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic req_type_i = 1'b0;
  logic [CoordBits-1:0] sample_x_i = '0;
  logic [CoordBits-1:0] sample_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  edge_t got_edge;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  rrt_tree_extend_core i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .req_type_i, .sample_x_i, .sample_y_i,
    .out_valid_o, .out_stall_i,
    .accepted_o(got_edge.accepted), .near_x_o(got_edge.near_x),
    .near_y_o(got_edge.near_y), .new_x_o(got_edge.new_x),
    .new_y_o(got_edge.new_y), .new_index_o(got_edge.new_index),
    .reached_start_o(got_edge.reached_start), .tree_done_o(got_edge.tree_done)
  );

  // Predicted tree state and register copies.
  int unsigned goal_x, goal_y, start_x, start_y, step_len, max_steps;
  int unsigned tree_xs[TreeDepth];
  int unsigned tree_ys[TreeDepth];
  int unsigned tree_count, steps_used;
  bit tree_finished;

  edge_t pending_edges[$];
  int unsigned mismatches, beats_sent, edges_seen, extends_grown;
  int unsigned quiet_cycles;
  bit calm_phase;

  // Largest u with u^2 * d2 <= d^2 * 2^(2F): floor(|d|/dist) in Q.F.
  function automatic longint unsigned unit_component(longint unsigned dabs,
                                                     longint unsigned d2);
    logic [127:0] rhs, lhs;
    longint unsigned u, c;
    u = 0;
    rhs = (128'(dabs) * 128'(dabs)) << (2 * UnitFracBits);
    for (int b = UnitFracBits; b >= 0; b--) begin
      c = u | (64'd1 << b);
      lhs = 128'(c * c) * 128'(d2);
      if (lhs <= rhs) u = c;
    end
    return u;
  endfunction

  function automatic int unsigned step_toward(int unsigned from, int unsigned to,
                                              longint unsigned d2);
    longint unsigned dabs, m, whole;
    dabs = (to >= from) ? to - from : from - to;
    m = longint'(step_len) * unit_component(dabs, d2);
    whole = m >> UnitFracBits;
    if (to >= from) return 32'((from + whole) & CoordMask);
    if ((m & ((64'd1 << UnitFracBits) - 1)) != 0) whole++;
    return 32'((from - whole) & CoordMask);
  endfunction

  function automatic edge_t grow_tree(bit kind, int unsigned sx, int unsigned sy);
    edge_t e;
    longint unsigned d2, best_d2;
    longint dx, dy;
    int unsigned best, wx, wy, slot;
    bit hit;
    e = '0;
    best = 0;
    best_d2 = 0;
    if (!kind) begin
      tree_xs[0] = goal_x;
      tree_ys[0] = goal_y;
      tree_count = 1;
      steps_used = 0;
      tree_finished = 1'b0;
      e.near_x = 10'(goal_x); e.near_y = 10'(goal_y);
      e.new_x = 10'(goal_x); e.new_y = 10'(goal_y);
      return e;
    end
    if (tree_count == 0 || tree_finished) begin
      e.tree_done = tree_finished;
      return e;
    end
    if (tree_count >= TreeDepth) begin
      tree_finished = 1'b1;
      e.tree_done = 1'b1;
      return e;
    end
    for (int unsigned i = 0; i < tree_count; i++) begin
      dx = longint'(tree_xs[i]) - longint'(sx);
      dy = longint'(tree_ys[i]) - longint'(sy);
      d2 = dx * dx + dy * dy;
      // later vertex wins a tie
      if (i == 0 || d2 <= best_d2) begin
        best = i;
        best_d2 = d2;
      end
    end
    if (best_d2 < longint'(step_len) * step_len) begin
      wx = sx; wy = sy;
    end else if (best_d2 == 0) begin
      wx = tree_xs[best]; wy = tree_ys[best];
    end else begin
      wx = step_toward(tree_xs[best], sx, best_d2);
      wy = step_toward(tree_ys[best], sy, best_d2);
    end
    slot = tree_count;
    tree_xs[slot] = wx;
    tree_ys[slot] = wy;
    tree_count++;
    steps_used = (steps_used + 1) & 12'hFFF;
    hit = (wx == start_x) && (wy == start_y);
    if (hit || steps_used >= max_steps || tree_count >= TreeDepth) tree_finished = 1'b1;
    e.accepted = 1'b1;
    e.near_x = 10'(tree_xs[best]); e.near_y = 10'(tree_ys[best]);
    e.new_x = 10'(wx); e.new_y = 10'(wy);
    e.new_index = 12'(slot);
    e.reached_start = hit;
    e.tree_done = tree_finished;
    return e;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH beat %0d %s: got %0d want %0d", edges_seen, what, got, want);
    mismatches++;
  endtask

  // Receiver: stall at random, check each beat against the oldest prediction.
  always @(posedge clk_i) begin
    edge_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_edges.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = pending_edges.pop_front();
        if (got_edge.accepted !== want.accepted)
          report_mismatch("accepted", got_edge.accepted, want.accepted);
        if (got_edge.near_x !== want.near_x)
          report_mismatch("near_x", got_edge.near_x, want.near_x);
        if (got_edge.near_y !== want.near_y)
          report_mismatch("near_y", got_edge.near_y, want.near_y);
        if (got_edge.new_x !== want.new_x)
          report_mismatch("new_x", got_edge.new_x, want.new_x);
        if (got_edge.new_y !== want.new_y)
          report_mismatch("new_y", got_edge.new_y, want.new_y);
        if (got_edge.new_index !== want.new_index)
          report_mismatch("new_index", got_edge.new_index, want.new_index);
        if (got_edge.reached_start !== want.reached_start)
          report_mismatch("reached_start", got_edge.reached_start, want.reached_start);
        if (got_edge.tree_done !== want.tree_done)
          report_mismatch("tree_done", got_edge.tree_done, want.tree_done);
      end
      edges_seen++;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= calm_phase ? 1'b0 : ($urandom_range(99) < 31);
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("watchdog expired after %0d idle cycles", QuietLimit);
      $display("rrt_tree_extend_core verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one beat; predict it once it is accepted. Valid stays up until the
  // next beat or an idle cycle drops it.
  task automatic send_request(bit kind, int unsigned sx, int unsigned sy);
    if (!calm_phase) begin
      while ($urandom_range(99) < 31) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    sample_x_i <= CoordBits'(sx);
    sample_y_i <= CoordBits'(sy);
    do @(posedge clk_i); while (in_stall_o);
    pending_edges.insert(pending_edges.size(), grow_tree(kind, sx, sy));
    beats_sent++;
    if (kind) extends_grown++;
    @(negedge clk_i);
  endtask

  // Hold the write enable up; the caller drops it after the last write.
  task automatic write_reg(cfg_idx_e idx, int unsigned value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CfgBits'(value);
    case (idx)
      CfgGoalX:  goal_x = value & CoordMask;
      CfgGoalY:  goal_y = value & CoordMask;
      CfgStartX: start_x = value & CoordMask;
      CfgStartY: start_y = value & CoordMask;
      CfgStep:   step_len = value & 8'hFF;
      CfgMax:    max_steps = value & 12'hFFF;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Drop valid, drain all predictions, then hold for the longest scan.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_edges.size() != 0) @(negedge clk_i);
    repeat (tree_count + 120) @(negedge clk_i);
  endtask

  task automatic program_tree(int unsigned gx, int unsigned gy, int unsigned tx,
                              int unsigned ty, int unsigned st, int unsigned mx);
    wait_idle();
    write_reg(CfgGoalX, gx);
    write_reg(CfgGoalY, gy);
    write_reg(CfgStartX, tx);
    write_reg(CfgStartY, ty);
    write_reg(CfgStep, st);
    write_reg(CfgMax, mx);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed_cases();
    // Extend before any restart is ignored, under reset registers.
    send_request(1'b1, 10, 10);
    send_request(1'b0, 0, 0);
    send_request(1'b1, 1023, 1023);
    send_request(1'b1, 0, 1023);
    send_request(1'b1, 1023, 0);
    send_request(1'b1, 2, 1);
    send_request(1'b1, 2, 1);
    program_tree(1023, 1023, 1000, 1023, 255, 4095);
    send_request(1'b0, 0, 0);
    send_request(1'b1, 0, 0);
    send_request(1'b1, 1023, 1023);
    send_request(1'b1, 1000, 1023);
    send_request(1'b1, 5, 5);
    // Step length one with a limit of a few extensions.
    program_tree(512, 512, 100, 100, 1, 3);
    send_request(1'b0, 0, 0);
    send_request(1'b1, 512, 512);
    send_request(1'b1, 600, 400);
    send_request(1'b1, 0, 1023);
    send_request(1'b1, 700, 700);
    send_request(1'b0, 0, 0);
    // Goal on the start does not end growth at the restart; a step limit of zero ends it at the first extension.
    program_tree(300, 300, 300, 300, 128, 0);
    send_request(1'b0, 0, 0);
    send_request(1'b1, 301, 300);
    send_request(1'b1, 310, 300);
  endtask

  task automatic test_random_growth(int unsigned count);
    int unsigned sx, sy;
    for (int unsigned n = 0; n < count; n++) begin
      calm_phase = (n >= count / 3) && (n < count / 3 + 20);
      sx = $urandom_range(1023);
      sy = $urandom_range(1023);
      if (n % 35 == 0 || $urandom_range(99) < 5) begin
        send_request(1'b0, sx, sy);
      end else if ($urandom_range(99) < 10) begin
        send_request(1'b1, start_x, start_y);
      end else if ($urandom_range(99) < 20) begin
        // sample with x near an existing vertex to make the short-step path likelier
        sx = (tree_xs[$urandom_range(tree_count > 0 ? tree_count - 1 : 0)]
              + $urandom_range(6)) & CoordMask;
        send_request(1'b1, sx, sy);
      end else begin
        send_request(1'b1, sx, sy);
      end
    end
    calm_phase = 1'b0;
  endtask

  initial begin
    goal_x = 0; goal_y = 0; start_x = 0; start_y = 0;
    step_len = DefStepLen;
    max_steps = DefMaxSteps;
    tree_count = 0;
    steps_used = 0;
    tree_finished = 1'b0;
    calm_phase = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_cases();
    program_tree($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                 $urandom_range(1023), $urandom_range(255, 16), 4095);
    test_random_growth(40);
    program_tree($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                 $urandom_range(1023), $urandom_range(15, 1), 40);
    test_random_growth(40);
    program_tree(0, 1023, 1023, 0, 255, $urandom_range(4095, 1));
    test_random_growth(37);
    wait_idle();
    $display("sent %0d beats (%0d extends), checked %0d result beats",
             beats_sent, extends_grown, edges_seen);
    if (mismatches == 0) begin
      $display("rrt_tree_extend_core verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("rrt_tree_extend_core verification failed");
    end
    $finish;
  end
endmodule
